// File: src/terrain_height_normal_sampler_top_macros.svh
// Assertion macros for the terrain sampler top level.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef TERRAIN_HEIGHT_NORMAL_SAMPLER_TOP_MACROS_SVH
`define TERRAIN_HEIGHT_NORMAL_SAMPLER_TOP_MACROS_SVH
// Property that must hold at every edge outside reset.
`define THNS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Implication checked at every edge outside reset.
`define THNS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) else $error(msg);
`endif

// File: src/thns_pkg.sv
// Shared constants and types for the terrain height and normal sampler.
// No dependencies.
package thns_pkg;
   localparam int GRID_MAX_DEF = 128;
   localparam int FIFO_DEPTH = 32;
   localparam int NSUM_W = 26;

   localparam logic CSR_GRID_COLUMNS = 1'b0;
   localparam logic CSR_GRID_ROWS = 1'b1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic signed [15:0] NORMAL_ONE = 16'sd16384;

   typedef logic signed [NSUM_W-1:0] nsum_type;

   typedef struct packed {
      logic in_range;
      logic signed [23:0] height;
   } side_type;
endpackage

// File: src/thns_vtx_mem.sv
// Vertex store copy: one write port, two registered read ports.
// Holds heights and packed normals; depends on nothing else.
module thns_vtx_mem #(
   parameter int AW = 14
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [23:0]       wr_height,
   input  logic [47:0]       wr_normal,
   input  logic [AW-1:0]     rd_addr0,
   input  logic [AW-1:0]     rd_addr1,
   output logic [23:0]       rd_height0,
   output logic [23:0]       rd_height1,
   output logic [47:0]       rd_normal0,
   output logic [47:0]       rd_normal1
);
   localparam int DEPTH = 2 ** AW;

   logic [23:0] height_mem [DEPTH];
   logic [47:0] normal_mem [DEPTH];

   // write one vertex, read two every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         height_mem[wr_addr] <= wr_height;
         normal_mem[wr_addr] <= wr_normal;
      end
      rd_height0 <= height_mem[rd_addr0];
      rd_height1 <= height_mem[rd_addr1];
      rd_normal0 <= normal_mem[rd_addr0];
      rd_normal1 <= normal_mem[rd_addr1];
   end
endmodule

// File: src/thns_norm.sv
// Normal renormalization pipeline: magnitude scaling, squares, then one
// result bit per stage for all three components. Uses thns_pkg.
module thns_norm (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  thns_pkg::side_type  in_side,
   input  thns_pkg::nsum_type  in_ns [3],
   output logic                out_valid,
   output thns_pkg::side_type  out_side,
   output logic signed [15:0]  out_normal [3]
);
   localparam int MAG_W = thns_pkg::NSUM_W - 1;
   localparam int NSTEP = 15;

   typedef struct packed {
      logic                valid;
      logic                zero;
      thns_pkg::side_type  side;
      logic [2:0]          neg;
      logic [31:0]         len2;
      logic [2:0][14:0]    lo;
      logic [2:0][63:0]    q;
      logic [2:0][48:0]    r;
      logic [2:0][59:0]    rhs;
   } step_type;

   // scale magnitudes below 2^15
   logic [MAG_W-1:0]   mag [3];
   logic [MAG_W-1:0]   big;
   logic [4:0]         top;
   logic [4:0]         sh;
   logic               a_valid_ff;
   thns_pkg::side_type a_side_ff;
   logic [2:0]         a_neg_ff, a_neg_in;
   logic [14:0]        a_m_ff [3];
   logic [14:0]        a_m_in [3];

   always_comb begin
      big = '0;
      for (int j = 0; j < 3; j++) begin
         a_neg_in[j] = in_ns[j][thns_pkg::NSUM_W-1];
         mag[j] = a_neg_in[j] ? MAG_W'(-in_ns[j]) : MAG_W'(in_ns[j]);
         big = big | mag[j];
      end
      top = '0;
      for (int p = 0; p < MAG_W; p++) begin
         if (big[p]) begin
            top = 5'(p);
         end
      end
      sh = (top > 5'd14) ? top - 5'd14 : 5'd0;
      for (int j = 0; j < 3; j++) begin
         a_m_in[j] = 15'(mag[j] >> sh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_side_ff <= in_side;
      a_neg_ff <= a_neg_in;
      for (int j = 0; j < 3; j++) begin
         a_m_ff[j] <= a_m_in[j];
      end
   end

   // square each component
   logic               b_valid_ff;
   thns_pkg::side_type b_side_ff;
   logic [2:0]         b_neg_ff;
   logic [29:0]        b_sq_ff [3];
   logic [29:0]        b_sq_in [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         b_sq_in[j] = a_m_ff[j] * a_m_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_side_ff <= a_side_ff;
      b_neg_ff <= a_neg_ff;
      for (int j = 0; j < 3; j++) begin
         b_sq_ff[j] <= b_sq_in[j];
      end
   end

   // squared length and per-component targets seed the bit search
   step_type st_ff [NSTEP+1];
   step_type st_in [NSTEP+1];

   always_comb begin
      // drop valid during reset
      st_in[0].valid = b_valid_ff && !reset;
      st_in[0].side = b_side_ff;
      st_in[0].neg = b_neg_ff;
      st_in[0].len2 = 32'(b_sq_ff[0]) + 32'(b_sq_ff[1]) + 32'(b_sq_ff[2]);
      st_in[0].zero = (st_in[0].len2 == 32'd0);
      for (int j = 0; j < 3; j++) begin
         st_in[0].lo[j] = '0;
         st_in[0].q[j] = 64'(st_in[0].len2);
         st_in[0].r[j] = 49'd0 - 49'(st_in[0].len2);
         st_in[0].rhs[j] = {b_sq_ff[j], 30'd0};
      end
   end

   always_ff @(posedge clock) begin
      st_ff[0] <= st_in[0];
   end

   // one result bit per stage, most significant first; q tracks (2*lo-1)^2*len2
   // and r tracks (2*lo-1)*len2 so each candidate costs shifts and adds
   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      localparam int S = NSTEP - 1 - k;
      logic [14:0]        cand [3];
      logic signed [66:0] lhs [3];
      logic signed [66:0] rnew [3];
      logic               take [3];

      always_comb begin
         st_in[k+1] = st_ff[k];
         st_in[k+1].valid = st_ff[k].valid && !reset;
         for (int j = 0; j < 3; j++) begin
            cand[j] = st_ff[k].lo[j] + (15'd1 << S);
            lhs[j] = $signed({3'b0, st_ff[k].q[j]})
                   + ($signed(67'($signed(st_ff[k].r[j]))) <<< (S + 2))
                   + $signed(67'(st_ff[k].len2) << (2 * S + 2));
            rnew[j] = $signed(67'($signed(st_ff[k].r[j])))
                    + $signed(67'(st_ff[k].len2) << (S + 1));
            take[j] = (cand[j] <= 15'd16384) &&
                      (lhs[j] <= $signed({7'b0, st_ff[k].rhs[j]}));
            if (take[j]) begin
               st_in[k+1].lo[j] = cand[j];
               st_in[k+1].q[j] = lhs[j][63:0];
               st_in[k+1].r[j] = rnew[j][48:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         st_ff[k+1] <= st_in[k+1];
      end
   end

   // apply signs and the outside-grid defaults
   logic signed [15:0] mag16 [3];

   always_comb begin
      out_valid = st_ff[NSTEP].valid;
      out_side = st_ff[NSTEP].side;
      for (int j = 0; j < 3; j++) begin
         mag16[j] = $signed({1'b0, st_ff[NSTEP].lo[j]});
         if (st_ff[NSTEP].zero) begin
            out_normal[j] = '0;
         end else if (st_ff[NSTEP].neg[j]) begin
            out_normal[j] = -mag16[j];
         end else begin
            out_normal[j] = mag16[j];
         end
      end
      if (!st_ff[NSTEP].side.in_range) begin
         out_side.height = '0;
         out_normal[0] = '0;
         out_normal[1] = thns_pkg::NORMAL_ONE;
         out_normal[2] = '0;
      end
   end
endmodule

// File: src/terrain_height_normal_sampler_top.sv
// Terrain height and normal sampler, top level.
// Uses thns_pkg, thns_vtx_mem, thns_norm and the assertion macro header.
//
// Usage: the req channel carries write beats (op 0) that load one vertex
// at vertex_index, and query beats (op 1) with a Q8.8 x,z position. Each
// query returns one rsp beat with height and unit normal interpolated
// over the triangle under the position; writes return nothing.
// Path: an accepted query passes stages 1 to 3 and the renormalization
// pipeline into the output queue; rsp_valid rises right after that write.
// Throughput: one beat per cycle while req_stall is low; ops mix freely. The
// vertex store is kept in two copies with two read ports each, so the four
// corners of a cell are read in the cycle of acceptance.
// Up to 32 queries may be in flight or queued; req_stall rises only when
// that many are outstanding, so the receiver may stall rsp without holding
// up the sender until the queue fills. A stalled rsp beat holds.
// Reset clears the grid size registers to 128 by 128 and empties the
// pipeline and queue; vertex contents are undefined until written.
`include "terrain_height_normal_sampler_top_macros.svh"
module terrain_height_normal_sampler_top #(
   parameter int GRID_MAX = thns_pkg::GRID_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [7:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [13:0]        req_vertex_index,
   input  logic signed [23:0] req_vertex_height,
   input  logic signed [15:0] req_vertex_normal_x,
   input  logic signed [15:0] req_vertex_normal_y,
   input  logic signed [15:0] req_vertex_normal_z,
   input  logic signed [15:0] req_query_x,
   input  logic signed [15:0] req_query_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_in_range,
   output logic signed [23:0] rsp_height_out,
   output logic signed [15:0] rsp_normal_out_x,
   output logic signed [15:0] rsp_normal_out_y,
   output logic signed [15:0] rsp_normal_out_z
);
   localparam int DEPTH = GRID_MAX * GRID_MAX;
   localparam int AW = $clog2(DEPTH);
   localparam int PW = $clog2(thns_pkg::FIFO_DEPTH);

   typedef struct packed {
      logic               in_range;
      logic signed [23:0] height;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
   } entry_type;

   // grid size registers
   logic [7:0] cols_ff, cols_in, rows_ff, rows_in;

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_write_enable) begin
         case (csr_index)
            thns_pkg::CSR_GRID_COLUMNS: cols_in = csr_write_data;
            thns_pkg::CSR_GRID_ROWS: rows_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 8'd128;
         rows_ff <= 8'd128;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   // accept, range check and corner addresses
   logic            req_acc, q_acc, wr_en, rsp_acc;
   logic [7:0]      eff_cols, eff_rows;
   logic [6:0]      cx, cz;
   logic            in_range;
   logic [15:0]     base, base_up;
   logic [AW-1:0]   addr0, addr1, addr2, addr3;
   logic [PW:0]     pend_ff, pend_in;

   assign req_stall = (pend_ff >= (PW + 1)'(thns_pkg::FIFO_DEPTH));
   assign req_acc = req_valid && !req_stall;
   assign q_acc = req_acc && (req_op == thns_pkg::OP_QUERY);
   assign wr_en = req_acc && (req_op == thns_pkg::OP_WRITE) &&
                  (32'(req_vertex_index) < DEPTH);

   always_comb begin
      eff_cols = (32'(cols_ff) > GRID_MAX) ? 8'(GRID_MAX) : cols_ff;
      eff_rows = (32'(rows_ff) > GRID_MAX) ? 8'(GRID_MAX) : rows_ff;
      cx = req_query_x[14:8];
      cz = req_query_z[14:8];
      in_range = !req_query_x[15] && !req_query_z[15] &&
                 (eff_cols >= 8'd2) && (eff_rows >= 8'd2) &&
                 (8'(cx) <= eff_cols - 8'd2) && (8'(cz) <= eff_rows - 8'd2);
      base = 16'(cz) * 16'(eff_cols) + 16'(cx);
      base_up = base + 16'(eff_cols);
      addr0 = AW'(base);
      addr2 = AW'(base + 16'd1);
      addr1 = AW'(base_up);
      addr3 = AW'(base_up + 16'd1);
   end

   // two store copies: cell bottom row and cell top row
   logic [23:0] h_rd [4];
   logic [47:0] n_rd [4];

   thns_vtx_mem #(.AW(AW)) u_mem_lo (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (AW'(req_vertex_index)),
      .wr_height  (req_vertex_height),
      .wr_normal  ({req_vertex_normal_z, req_vertex_normal_y, req_vertex_normal_x}),
      .rd_addr0   (addr0),
      .rd_addr1   (addr2),
      .rd_height0 (h_rd[0]),
      .rd_height1 (h_rd[2]),
      .rd_normal0 (n_rd[0]),
      .rd_normal1 (n_rd[2])
   );

   thns_vtx_mem #(.AW(AW)) u_mem_hi (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (AW'(req_vertex_index)),
      .wr_height  (req_vertex_height),
      .wr_normal  ({req_vertex_normal_z, req_vertex_normal_y, req_vertex_normal_x}),
      .rd_addr0   (addr1),
      .rd_addr1   (addr3),
      .rd_height0 (h_rd[1]),
      .rd_height1 (h_rd[3]),
      .rd_normal0 (n_rd[1]),
      .rd_normal1 (n_rd[3])
   );

   // stage 1: fractions travel beside the memory read
   logic       s1_valid_ff, s1_range_ff;
   logic [7:0] s1_fx_ff, s1_fz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= q_acc;
      end
      s1_range_ff <= in_range;
      s1_fx_ff <= req_query_x[7:0];
      s1_fz_ff <= req_query_z[7:0];
   end

   // stage 2: triangle weights and corner products
   logic [8:0]               fsum;
   logic [8:0]               w [4];
   logic signed [33:0]       ph_ff [4];
   logic signed [33:0]       ph_in [4];
   thns_pkg::nsum_type       pn_ff [4][3];
   thns_pkg::nsum_type       pn_in [4][3];
   logic                     s2_valid_ff, s2_range_ff;

   always_comb begin
      fsum = 9'(s1_fx_ff) + 9'(s1_fz_ff);
      if (fsum <= 9'd256) begin
         w[0] = 9'd256 - fsum;
         w[1] = 9'(s1_fz_ff);
         w[2] = 9'(s1_fx_ff);
         w[3] = 9'd0;
      end else begin
         w[0] = 9'd0;
         w[1] = 9'd256 - 9'(s1_fx_ff);
         w[2] = 9'd256 - 9'(s1_fz_ff);
         w[3] = fsum - 9'd256;
      end
      for (int i = 0; i < 4; i++) begin
         ph_in[i] = $signed(h_rd[i]) * $signed({1'b0, w[i]});
         for (int j = 0; j < 3; j++) begin
            pn_in[i][j] = $signed(n_rd[i][16*j +: 16]) * $signed({1'b0, w[i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_range_ff <= s1_range_ff;
      for (int i = 0; i < 4; i++) begin
         ph_ff[i] <= ph_in[i];
         for (int j = 0; j < 3; j++) begin
            pn_ff[i][j] <= pn_in[i][j];
         end
      end
   end

   // stage 3: weighted sums
   logic signed [35:0]  hs_ff, hs_in;
   logic signed [35:0]  hr_full;
   thns_pkg::nsum_type  ns_ff [3];
   thns_pkg::nsum_type  ns_in [3];
   logic                s3_valid_ff, s3_range_ff;
   thns_pkg::side_type  s3_side;

   always_comb begin
      hs_in = ph_ff[0] + ph_ff[1] + ph_ff[2] + ph_ff[3];
      for (int j = 0; j < 3; j++) begin
         ns_in[j] = pn_ff[0][j] + pn_ff[1][j] + pn_ff[2][j] + pn_ff[3][j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_range_ff <= s2_range_ff;
      hs_ff <= hs_in;
      for (int j = 0; j < 3; j++) begin
         ns_ff[j] <= ns_in[j];
      end
   end

   // round height to nearest, ties up
   always_comb begin
      hr_full = hs_ff + 36'sd128;
      s3_side.in_range = s3_range_ff;
      s3_side.height = hr_full[31:8];
   end

   // renormalize the normal
   logic               n_valid;
   thns_pkg::side_type n_side;
   logic signed [15:0] n_normal [3];

   thns_norm u_norm (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s3_valid_ff),
      .in_side    (s3_side),
      .in_ns      (ns_ff),
      .out_valid  (n_valid),
      .out_side   (n_side),
      .out_normal (n_normal)
   );

   // result queue
   entry_type   fifo_mem [thns_pkg::FIFO_DEPTH];
   entry_type   head;
   logic [PW:0] wp_ff, rp_ff, fill;

   assign rsp_valid = (wp_ff != rp_ff);
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign fill = wp_ff - rp_ff;
   assign head = fifo_mem[rp_ff[PW-1:0]];
   assign rsp_in_range = head.in_range;
   assign rsp_height_out = head.height;
   assign rsp_normal_out_x = head.nx;
   assign rsp_normal_out_y = head.ny;
   assign rsp_normal_out_z = head.nz;

   // count queries not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if (q_acc && !rsp_acc) begin
         pend_in = pend_ff + (PW + 1)'(1);
      end else if (!q_acc && rsp_acc) begin
         pend_in = pend_ff - (PW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         if (n_valid) begin
            wp_ff <= wp_ff + (PW + 1)'(1);
         end
         if (rsp_acc) begin
            rp_ff <= rp_ff + (PW + 1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (n_valid) begin
         fifo_mem[wp_ff[PW-1:0]] <= {n_side.in_range, n_side.height,
                                     n_normal[0], n_normal[1], n_normal[2]};
      end
   end

   `THNS_ASSERT(a_pend_bound, pend_ff <= (PW + 1)'(thns_pkg::FIFO_DEPTH), "too many queries outstanding")
   `THNS_ASSERT(a_fill_le_pend, fill <= pend_ff, "queue holds more than outstanding queries")
   `THNS_ASSERT_IMP(a_rsp_pend, rsp_valid, (pend_ff != '0), "result with no query outstanding")
   `THNS_ASSERT_IMP(a_pend_up, q_acc && !rsp_acc, ##1 (pend_ff == $past(pend_ff) + (PW + 1)'(1)), "query not counted")
endmodule
